// ===== design/bilinear_plane_resize_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BILINEAR_PLANE_RESIZE_CORE_DEFINES_SVH
`define BILINEAR_PLANE_RESIZE_CORE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define BPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bilinear_plane_resize_core assertion failed");

// Checked on every rising edge, reset included.
`define BPR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bilinear_plane_resize_core reset assertion failed");

`endif

// ===== design/bpr_pkg.sv =====
package bpr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FX_W = 17;
  localparam int H_W = 34;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 21;
  localparam logic [FX_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Y = 3'd5;

  localparam int MODE_LOAD = 0;

endpackage

// ===== design/bpr_channels.sv =====
interface bpr_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic signed [15:0] sample;
  modport source(output valid, output mode, output sample, input ready);
  modport sink(input valid, input mode, input sample, output ready);
endinterface

interface bpr_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] pixel;
  logic last_of_plane;
  modport source(output valid, output pixel, output last_of_plane, input ready);
  modport sink(input valid, input pixel, input last_of_plane, output ready);
endinterface

// ===== design/bilinear_plane_resize_core.sv =====
// Bilinear resize of one plane of signed Q8.8 samples.
// The items channel carries requests: mode 0 writes the next source sample
// into the frame store in raster order, mode 1 asks for the next output
// pixel in raster order. The results channel returns one pixel per produce
// request, with last_of_plane set on the final pixel of the plane.
// The configuration port writes sizes and reciprocal scales; the user must
// do so only while idle, as the block itself does not enforce it.
// A front end takes a request, then forms a command for a two-entry queue,
// through F_PUSH for a load or F_LOC then F_PUSH for a produce; it takes no
// new request until that command is pushed. The back end reads the four
// neighbors from the single-port frame store one per cycle and blends them;
// it takes no new command until its pixel leaves B_OUT. Those four reads
// and the blend steps set the pixel rate. Reset clears all control state and
// the configuration to its defaults; the frame store holds no defined data
// until loaded. A receiver that stalls holds the output register; the queue
// then fills and the items channel drops ready until space frees up.
module bilinear_plane_resize_core #(
  parameter int MAX_IN_WIDTH = 256,
  parameter int MAX_IN_HEIGHT = 256,
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_OUT_HEIGHT = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
  bpr_in_if.sink items,
  bpr_out_if.source results
);
  import bpr_pkg::*;

  localparam int AW = $clog2(MAX_IN_WIDTH * MAX_IN_HEIGHT);
  localparam int IWW = $clog2(MAX_IN_WIDTH + 1);
  localparam int CMD_W = 2 + SAMPLE_W + AW + IWW + 2 * FX_W;

  logic push_valid, push_ready, pop_valid, pop_ready;
  logic [CMD_W-1:0] push_data, pop_data;

  bpr_front #(
    .MAX_IN_WIDTH(MAX_IN_WIDTH),
    .MAX_IN_HEIGHT(MAX_IN_HEIGHT),
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_OUT_HEIGHT(MAX_OUT_HEIGHT),
    .AW(AW),
    .IWW(IWW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .items(items),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data)
  );

  bpr_queue #(
    .W(CMD_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data(push_data),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data)
  );

  bpr_back #(
    .MAX_IN_WIDTH(MAX_IN_WIDTH),
    .MAX_IN_HEIGHT(MAX_IN_HEIGHT),
    .AW(AW),
    .IWW(IWW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data),
    .results(results)
  );

endmodule

// ===== design/bpr_front.sv =====
module bpr_front #(
  parameter int MAX_IN_WIDTH = 256,
  parameter int MAX_IN_HEIGHT = 256,
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int MAX_OUT_HEIGHT = 1024,
  parameter int AW = 16,
  parameter int IWW = 9,
  localparam int CMD_W = 2 + bpr_pkg::SAMPLE_W + AW + IWW + 2 * bpr_pkg::FX_W
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
  bpr_in_if.sink items,
  output logic push_valid,
  input  logic push_ready,
  output logic [CMD_W-1:0] push_data
);
  import bpr_pkg::*;

  localparam int DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int IHW = $clog2(MAX_IN_HEIGHT + 1);
  localparam int CW = $clog2(MAX_OUT_WIDTH + 1);
  localparam int RW = $clog2(MAX_OUT_HEIGHT + 1);
  localparam int PXW = CW + 21;
  localparam int PYW = RW + 21;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LOC  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  typedef struct packed {
    logic is_load;
    logic last;
    logic signed [SAMPLE_W-1:0] sample;
    logic [AW-1:0] a0;
    logic [IWW-1:0] iw;
    logic [FX_W-1:0] fx;
    logic [FX_W-1:0] fy;
  } cmd_t;

  fstate_t state;
  cmd_t cmd;
  logic [8:0] in_width, in_height;
  logic [10:0] out_width, out_height;
  logic [20:0] inv_scale_x, inv_scale_y;
  logic [IWW-1:0] iw;
  logic [IHW-1:0] ih;
  logic [CW-1:0] ow, col, col_eff, col_inc, col_next;
  logic [RW-1:0] oh, row, row_tmp, row_eff, row_inc, row_next;
  logic [AW-1:0] lp;
  logic [AW:0] lp_inc;
  logic [PXW-1:0] px;
  logic [PYW-1:0] py;
  logic [PXW-17:0] ipx;
  logic [PYW-17:0] ipy;
  logic [IWW-1:0] sx;
  logic [IHW-1:0] sy;
  logic [FX_W-1:0] fx, fy;
  logic last_hit, accept;

  assign accept = items.valid && items.ready;
  assign items.ready = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_data = cmd;

  always_comb begin
    if (32'(in_width) < 32'd2) iw = IWW'(2);
    else if (32'(in_width) > 32'(MAX_IN_WIDTH)) iw = IWW'(MAX_IN_WIDTH);
    else iw = IWW'(in_width);
    if (32'(in_height) < 32'd2) ih = IHW'(2);
    else if (32'(in_height) > 32'(MAX_IN_HEIGHT)) ih = IHW'(MAX_IN_HEIGHT);
    else ih = IHW'(in_height);
    if (out_width == 11'd0) ow = CW'(1);
    else if (32'(out_width) > 32'(MAX_OUT_WIDTH)) ow = CW'(MAX_OUT_WIDTH);
    else ow = CW'(out_width);
    if (out_height == 11'd0) oh = RW'(1);
    else if (32'(out_height) > 32'(MAX_OUT_HEIGHT)) oh = RW'(MAX_OUT_HEIGHT);
    else oh = RW'(out_height);
  end

  always_comb begin
    if (col >= ow) begin
      col_eff = '0;
      row_tmp = row + RW'(1);
    end else begin
      col_eff = col;
      row_tmp = row;
    end
    row_eff = (row_tmp >= oh) ? '0 : row_tmp;
    last_hit = (col_eff == ow - CW'(1)) && (row_eff == oh - RW'(1));
    col_inc = col_eff + CW'(1);
    row_inc = row_eff + RW'(1);
    if (col_inc >= ow) begin
      col_next = '0;
      row_next = (row_inc >= oh) ? '0 : row_inc;
    end else begin
      col_next = col_inc;
      row_next = row_eff;
    end
    lp_inc = {1'b0, lp} + (AW + 1)'(1);
  end

  always_comb begin
    ipx = px[PXW-1:16];
    ipy = py[PYW-1:16];
    if (32'(ipx) >= 32'(iw) - 32'd1) begin
      sx = iw - IWW'(2);
      fx = ONE_Q16;
    end else begin
      sx = IWW'(ipx);
      fx = {1'b0, px[15:0]};
    end
    if (32'(ipy) >= 32'(ih) - 32'd1) begin
      sy = ih - IHW'(2);
      fy = ONE_Q16;
    end else begin
      sy = IHW'(ipy);
      fy = {1'b0, py[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      in_width <= 9'd2;
      in_height <= 9'd2;
      out_width <= 11'd1;
      out_height <= 11'd1;
      inv_scale_x <= 21'h10000;
      inv_scale_y <= 21'h10000;
      col <= '0;
      row <= '0;
      lp <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IN_WIDTH: in_width <= cfg_data[8:0];
          CFG_IN_HEIGHT: in_height <= cfg_data[8:0];
          CFG_OUT_WIDTH: out_width <= cfg_data[10:0];
          CFG_OUT_HEIGHT: out_height <= cfg_data[10:0];
          CFG_INV_SCALE_X: inv_scale_x <= cfg_data;
          CFG_INV_SCALE_Y: inv_scale_y <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (items.mode == 1'(MODE_LOAD)) begin
              if (32'(lp_inc) >= 32'(iw) * 32'(ih) || 32'(lp_inc) >= 32'(DEPTH)) begin
                lp <= '0;
              end else begin
                lp <= AW'(lp_inc);
              end
              state <= F_PUSH;
            end else begin
              col <= col_next;
              row <= row_next;
              state <= F_LOC;
            end
          end
        end
        F_LOC: state <= F_PUSH;
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      cmd.is_load <= (items.mode == 1'(MODE_LOAD));
      cmd.sample <= items.sample;
      cmd.a0 <= lp;
      cmd.last <= last_hit;
      px <= PXW'(col_eff) * PXW'(inv_scale_x);
      py <= PYW'(row_eff) * PYW'(inv_scale_y);
    end
    if (state == F_LOC) begin
      cmd.a0 <= AW'(32'(sy) * 32'(iw) + 32'(sx));
      cmd.iw <= iw;
      cmd.fx <= fx;
      cmd.fy <= fy;
    end
  end

endmodule

// ===== design/bpr_queue.sv =====
module bpr_queue #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [W-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [W-1:0] pop_data
);
  import bpr_pkg::*;

  logic [W-1:0] slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== design/bpr_back.sv =====
module bpr_back #(
  parameter int MAX_IN_WIDTH = 256,
  parameter int MAX_IN_HEIGHT = 256,
  parameter int AW = 16,
  parameter int IWW = 9,
  localparam int CMD_W = 2 + bpr_pkg::SAMPLE_W + AW + IWW + 2 * bpr_pkg::FX_W
) (
  input  logic clk,
  input  logic rst,
  input  logic pop_valid,
  output logic pop_ready,
  input  logic [CMD_W-1:0] pop_data,
  bpr_out_if.source results
);
  import bpr_pkg::*;

  localparam int DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;

  typedef enum logic [7:0] {
    B_IDLE = 8'b00000001,
    B_RD0  = 8'b00000010,
    B_RD1  = 8'b00000100,
    B_RD2  = 8'b00001000,
    B_RD3  = 8'b00010000,
    B_H1   = 8'b00100000,
    B_V    = 8'b01000000,
    B_OUT  = 8'b10000000
  } bstate_t;

  typedef struct packed {
    logic is_load;
    logic last;
    logic signed [SAMPLE_W-1:0] sample;
    logic [AW-1:0] a0;
    logic [IWW-1:0] iw;
    logic [FX_W-1:0] fx;
    logic [FX_W-1:0] fy;
  } cmd_t;

  function automatic logic signed [H_W-1:0] hblend(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [FX_W-1:0] w
  );
    logic signed [SAMPLE_W:0] d;
    logic signed [FX_W:0] ws;
    logic signed [H_W:0] p;
    logic signed [H_W:0] base;
    logic signed [H_W:0] sum;
    d = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
    ws = {1'b0, w};
    p = d * ws;
    base = {{3{a[SAMPLE_W-1]}}, a, 16'h0000};
    sum = base + p;
    return sum[H_W-1:0];
  endfunction

  bstate_t state;
  cmd_t head, c;
  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata, s0;
  logic signed [H_W-1:0] h0, h1;
  logic signed [H_W:0] hd;
  logic signed [H_W+FX_W+1:0] vprod;
  logic signed [55:0] vsum;
  logic signed [23:0] r;
  logic signed [SAMPLE_W-1:0] sat;
  logic [AW-1:0] raddr;
  logic re, we;

  assign head = pop_data;
  assign pop_ready = (state == B_IDLE);
  assign we = (state == B_IDLE) && pop_valid && head.is_load;
  assign re = (state == B_RD0) || (state == B_RD1) || (state == B_RD2) || (state == B_RD3);

  always_comb begin
    case (state)
      B_RD1: raddr = c.a0 + AW'(1);
      B_RD2: raddr = c.a0 + AW'(c.iw);
      B_RD3: raddr = c.a0 + AW'(c.iw) + AW'(1);
      default: raddr = c.a0;
    endcase
    hd = {h1[H_W-1], h1} - {h0[H_W-1], h0};
    vsum = {{6{h0[H_W-1]}}, h0, 16'h0000} + {{3{vprod[H_W+FX_W+1]}}, vprod}
         + 56'sh80000000;
    r = vsum[55:32];
    if (r > 24'sd32767) sat = 16'sh7FFF;
    else if (r < -24'sd32768) sat = 16'sh8000;
    else sat = r[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (we) mem[head.a0] <= head.sample;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      results.valid <= 1'b0;
    end else begin
      if (state == B_OUT && (!results.valid || results.ready)) results.valid <= 1'b1;
      else if (results.ready) results.valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop_valid && !head.is_load) state <= B_RD0;
        end
        B_RD0: state <= B_RD1;
        B_RD1: state <= B_RD2;
        B_RD2: state <= B_RD3;
        B_RD3: state <= B_H1;
        B_H1: state <= B_V;
        B_V: state <= B_OUT;
        B_OUT: begin
          if (!results.valid || results.ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: c <= head;
      B_RD1: s0 <= rdata;
      B_RD2: h0 <= hblend(s0, rdata, c.fx);
      B_RD3: s0 <= rdata;
      B_H1: h1 <= hblend(s0, rdata, c.fx);
      B_V: vprod <= hd * $signed({1'b0, c.fy});
      B_OUT: begin
        if (!results.valid || results.ready) begin
          results.pixel <= sat;
          results.last_of_plane <= c.last;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/bpr_checker.sv =====
`include "bilinear_plane_resize_core_defines.svh"

module bpr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] pixel,
  input logic last_of_plane
);
  import bpr_pkg::*;

  `BPR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `BPR_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(pixel) && $stable(last_of_plane))
  `BPR_ASSERT(a_front_busy, in_valid && in_ready |=> !in_ready)
  `BPR_ASSERT_RST(a_reset_idle, rst |=> !out_valid)

endmodule

bind bilinear_plane_resize_core bpr_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(items.valid),
  .in_ready(items.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .pixel(results.pixel),
  .last_of_plane(results.last_of_plane)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bpr_pkg::*;

  typedef struct packed {
    logic mode;
    logic signed [15:0] sample;
  } request_t;

  typedef struct packed {
    logic signed [15:0] pixel;
    logic last;
  } pixel_t;

  localparam int LIMIT = 2000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bpr_in_if items();
  bpr_out_if results();

  bilinear_plane_resize_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .items(items),
    .results(results)
  );

  request_t pending_requests[$];
  pixel_t expected_pixels[$];
  logic [15:0] frame_copy[int];
  int load_pos, col_pos, row_pos;
  int in_w_reg, in_h_reg, out_w_reg, out_h_reg, inv_x_reg, inv_y_reg;
  int errors, pixels_checked, loads_sent, produces_sent;
  int cycle_count;
  bit idle_free;
  bit hold_off_req;
  int hold_off_left;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int clampi(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void place(int idx, int inv, int size, output int pos,
                                output longint wt);
    longint p;
    longint ip;
    p = longint'(idx) * longint'(inv);
    ip = p >>> 16;
    if (ip >= size - 1) begin
      pos = size - 2;
      wt = 65536;
    end else begin
      pos = int'(ip);
      wt = p & 64'hFFFF;
    end
  endfunction

  function automatic longint sample_at(int addr);
    logic signed [15:0] s;
    s = frame_copy.exists(addr) ? frame_copy[addr] : 16'd0;
    return longint'(s);
  endfunction

  function automatic void predict_request(request_t r);
    int iw, ih, ow, oh, sx, sy, a0, a1;
    longint fx, fy, h0, h1, v, q;
    pixel_t e;
    iw = clampi(in_w_reg, 2, 256);
    ih = clampi(in_h_reg, 2, 256);
    ow = clampi(out_w_reg, 1, 1024);
    oh = clampi(out_h_reg, 1, 1024);
    if (r.mode == 1'b0) begin
      frame_copy[load_pos] = r.sample;
      load_pos++;
      if (load_pos >= iw * ih) load_pos = 0;
      return;
    end
    if (col_pos >= ow) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= oh) row_pos = 0;
    place(col_pos, inv_x_reg, iw, sx, fx);
    place(row_pos, inv_y_reg, ih, sy, fy);
    a0 = sy * iw + sx;
    a1 = a0 + iw;
    h0 = sample_at(a0) * (65536 - fx) + sample_at(a0 + 1) * fx;
    h1 = sample_at(a1) * (65536 - fx) + sample_at(a1 + 1) * fx;
    v = h0 * (65536 - fy) + h1 * fy;
    q = (v + (64'sd1 <<< 31)) >>> 32;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    e.pixel = q[15:0];
    e.last = (col_pos == ow - 1) && (row_pos == oh - 1);
    expected_pixels.push_back(e);
    col_pos++;
    if (col_pos >= ow) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= oh) row_pos = 0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      items.valid <= 1'b0;
      items.mode <= 1'b0;
      items.sample <= '0;
    end else begin
      if (items.valid && items.ready) begin
        predict_request('{items.mode, items.sample});
      end
      if (!items.valid || items.ready) begin
        if (pending_requests.size() > 0 && (idle_free || $urandom_range(99) >= 8)) begin
          request_t r;
          r = pending_requests.pop_front();
          items.valid <= 1'b1;
          items.mode <= r.mode;
          items.sample <= r.sample;
          if (r.mode) produces_sent++;
          else loads_sent++;
        end else begin
          items.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_off_left <= 0;
    end else if (hold_off_req && hold_off_left == 0) begin
      hold_off_left <= 300;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel %0d", results.pixel);
          errors++;
        end else begin
          pixel_t e;
          e = expected_pixels.pop_front();
          if (results.pixel !== e.pixel) begin
            $error("pixel expected %0d actual %0d", e.pixel, results.pixel);
            errors++;
          end
          if (results.last_of_plane !== e.last) begin
            $error("last_of_plane expected %0d actual %0d", e.last,
                   results.last_of_plane);
            errors++;
          end
          pixels_checked++;
        end
      end
      if ((hold_off_req && hold_off_left == 0) || hold_off_left > 1) begin
        results.ready <= 1'b0;
      end else if (hold_off_left == 1) begin
        results.ready <= 1'b1;
      end else begin
        results.ready <= idle_free || ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("bilinear_plane_resize_core test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IN_WIDTH: in_w_reg = value & 32'h1FF;
      CFG_IN_HEIGHT: in_h_reg = value & 32'h1FF;
      CFG_OUT_WIDTH: out_w_reg = value & 32'h7FF;
      CFG_OUT_HEIGHT: out_h_reg = value & 32'h7FF;
      CFG_INV_SCALE_X: inv_x_reg = value & 32'h1FFFFF;
      CFG_INV_SCALE_Y: inv_y_reg = value & 32'h1FFFFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || items.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input int iw, input int ih, input int ow, input int oh,
                           input int ix, input int iy);
    drain();
    write_reg(CFG_IN_WIDTH, iw);
    write_reg(CFG_IN_HEIGHT, ih);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    write_reg(CFG_INV_SCALE_X, ix);
    write_reg(CFG_INV_SCALE_Y, iy);
  endtask

  function automatic logic signed [15:0] rand_sample(int kind);
    case (kind % 4)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic queue_plane(input int n_load, input int n_produce, input int kind);
    for (int i = 0; i < n_load; i++)
      pending_requests.push_back('{1'b0, (kind >= 0) ? rand_sample(kind + i) : 16'($urandom())});
    for (int i = 0; i < n_produce; i++)
      pending_requests.push_back('{1'b1, 16'($urandom())});
  endtask

  initial begin
    int iw, ih, ow, oh;
    errors = 0;
    pixels_checked = 0;
    loads_sent = 0;
    produces_sent = 0;
    cycle_count = 0;
    idle_free = 0;
    hold_off_req = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items.valid = 1'b0;
    items.mode = 1'b0;
    items.sample = '0;
    results.ready = 1'b0;
    in_w_reg = 2; in_h_reg = 2; out_w_reg = 1; out_h_reg = 1;
    inv_x_reg = 65536; inv_y_reg = 65536;
    load_pos = 0; col_pos = 0; row_pos = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    pending_requests.push_back('{1'b0, 16'sh7FFF});
    pending_requests.push_back('{1'b0, 16'sh8000});
    pending_requests.push_back('{1'b0, 16'sh8000});
    pending_requests.push_back('{1'b0, 16'sh7FFF});
    pending_requests.push_back('{1'b1, 16'h0});
    pending_requests.push_back('{1'b1, 16'hFFFF});
    configure(0, 0, 0, 0, 0, 0);
    queue_plane(4, 3, 0);
    configure(511, 511, 2047, 2047, 32768, 32768);
    queue_plane(4, 0, 1);
    configure(2, 2, 3, 3, 21845, 21845);
    queue_plane(4, 9, 0);
    configure(256, 2, 2, 1, 2097151, 1048576);
    queue_plane(512, 3, 1);
    configure(3, 3, 1024, 1, 1, 1);
    queue_plane(9, 4, 2);
    configure(4, 3, 2, 2, 65536, 65536);
    queue_plane(12, 4, 2);
    drain();
    write_reg(CFG_OUT_WIDTH, 1);
    queue_plane(0, 3, -1);

    configure(8, 8, 12, 12, 43690, 43690);
    queue_plane(64, 0, -1);
    drain();
    hold_off_req = 1;
    queue_plane(0, 40, -1);
    @(posedge clk);
    hold_off_req <= 1'b0;

    idle_free = 1;
    configure(5, 6, 7, 4, 45000, 90000);
    queue_plane(30, 40, -1);
    drain();
    idle_free = 0;

    for (int k = 0; k < 12; k++) begin
      iw = $urandom_range(2, 12);
      ih = $urandom_range(2, 12);
      ow = $urandom_range(1, 14);
      oh = $urandom_range(1, 10);
      configure(iw, ih, ow, oh, $urandom_range(1, 4 * 65536),
                $urandom_range(1, 4 * 65536));
      queue_plane(iw * ih, $urandom_range(1, ow * oh + 2), -1);
      if (k % 3 == 0) queue_plane(iw * ih, $urandom_range(1, 8), -1);
    end
    drain();
    $display("Covered %0d loads and %0d produce requests; %0d pixels checked.",
             loads_sent, produces_sent, pixels_checked);
    if (errors == 0) begin
      $display("bilinear_plane_resize_core test passed");
    end else begin
      $display("bilinear_plane_resize_core test failed");
    end
    $finish;
  end

endmodule
